/* design/fpd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_pkg: flight phase detector shared types and constants
// Payload structs, phase and register index codes, register reset values.
// ----------------------------------------------------------------------------
package fpd_pkg;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_LAUNCH = 2'd1,
      PHASE_COAST  = 2'd2,
      PHASE_APOGEE = 2'd3
   } phase_type;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LAUNCH_ACCEL_THRESHOLD  = 3'd0,
      CSR_LAUNCH_HOLD_COUNT       = 3'd1,
      CSR_BURNOUT_ACCEL_THRESHOLD = 3'd2,
      CSR_BURNOUT_HOLD_COUNT      = 3'd3,
      CSR_MIN_BURN_MS             = 3'd4,
      CSR_MAX_BURN_MS             = 3'd5,
      CSR_APOGEE_HOLD_COUNT       = 3'd6,
      CSR_COAST_TIMEOUT_MS        = 3'd7
   } csr_index_type;

   localparam logic [14:0]        LAUNCH_ACCEL_THRESHOLD_RESET  = 15'd6144;
   localparam logic [7:0]         LAUNCH_HOLD_COUNT_RESET       = 8'd50;
   localparam logic signed [15:0] BURNOUT_ACCEL_THRESHOLD_RESET = 16'sd200;
   localparam logic [7:0]         BURNOUT_HOLD_COUNT_RESET      = 8'd33;
   localparam logic [15:0]        MIN_BURN_MS_RESET             = 16'd5000;
   localparam logic [15:0]        MAX_BURN_MS_RESET             = 16'd8000;
   localparam logic [7:0]         APOGEE_HOLD_COUNT_RESET       = 8'd33;
   localparam logic [15:0]        COAST_TIMEOUT_MS_RESET        = 16'd20000;

   localparam int unsigned COAST_LOCKOUT_MS_DEFAULT = 10000;

   localparam logic [7:0] SERVO_HOME_DEG = 8'd180;

   typedef struct packed {
      logic [31:0]        time_ms;
      logic signed [15:0] accel_vertical;
      logic [23:0]        pressure;
   } req_type;

   typedef struct packed {
      phase_type  phase;
      logic       servo_write;
      logic [7:0] servo_angle;
   } rsp_type;

   typedef struct packed {
      logic [14:0]        launch_accel_threshold;
      logic [7:0]         launch_hold_count;
      logic signed [15:0] burnout_accel_threshold;
      logic [7:0]         burnout_hold_count;
      logic [15:0]        min_burn_ms;
      logic [15:0]        max_burn_ms;
      logic [7:0]         apogee_hold_count;
      logic [15:0]        coast_timeout_ms;
   } cfg_type;

   // phase decision handed from the state pass to the servo sweep stages
   typedef struct packed {
      phase_type   phase;
      logic        sweep;
      logic        brake_close;
      logic [31:0] coast_elapsed;
   } stage_type;

endpackage
`default_nettype wire

/* design/fpd_csr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_csr: configuration registers
// Write-only register file holding thresholds, hold counts and time limits.
// ----------------------------------------------------------------------------
module fpd_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [fpd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [fpd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output fpd_pkg::cfg_type                          cfg
);

   fpd_pkg::cfg_type cfg_ff;
   fpd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (fpd_pkg::csr_index_type'(csr_index))
            fpd_pkg::CSR_LAUNCH_ACCEL_THRESHOLD:  cfg_in.launch_accel_threshold = csr_wdata[14:0];
            fpd_pkg::CSR_LAUNCH_HOLD_COUNT:       cfg_in.launch_hold_count = csr_wdata[7:0];
            fpd_pkg::CSR_BURNOUT_ACCEL_THRESHOLD: cfg_in.burnout_accel_threshold = csr_wdata;
            fpd_pkg::CSR_BURNOUT_HOLD_COUNT:      cfg_in.burnout_hold_count = csr_wdata[7:0];
            fpd_pkg::CSR_MIN_BURN_MS:             cfg_in.min_burn_ms = csr_wdata;
            fpd_pkg::CSR_MAX_BURN_MS:             cfg_in.max_burn_ms = csr_wdata;
            fpd_pkg::CSR_APOGEE_HOLD_COUNT:       cfg_in.apogee_hold_count = csr_wdata[7:0];
            fpd_pkg::CSR_COAST_TIMEOUT_MS:        cfg_in.coast_timeout_ms = csr_wdata;
            default:                              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.launch_accel_threshold  <= fpd_pkg::LAUNCH_ACCEL_THRESHOLD_RESET;
         cfg_ff.launch_hold_count       <= fpd_pkg::LAUNCH_HOLD_COUNT_RESET;
         cfg_ff.burnout_accel_threshold <= fpd_pkg::BURNOUT_ACCEL_THRESHOLD_RESET;
         cfg_ff.burnout_hold_count      <= fpd_pkg::BURNOUT_HOLD_COUNT_RESET;
         cfg_ff.min_burn_ms             <= fpd_pkg::MIN_BURN_MS_RESET;
         cfg_ff.max_burn_ms             <= fpd_pkg::MAX_BURN_MS_RESET;
         cfg_ff.apogee_hold_count       <= fpd_pkg::APOGEE_HOLD_COUNT_RESET;
         cfg_ff.coast_timeout_ms        <= fpd_pkg::COAST_TIMEOUT_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* design/fpd_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_core: flight phase state pass
// Steps the phase machine and its sample counters once per accepted word.
// ----------------------------------------------------------------------------
module fpd_core #(
   parameter int unsigned COAST_LOCKOUT_MS = fpd_pkg::COAST_LOCKOUT_MS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire fpd_pkg::cfg_type cfg,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire fpd_pkg::req_type req_payload,
   output logic             stage_valid,
   input  wire logic        stage_ready,
   output fpd_pkg::stage_type stage_data
);

   fpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         launch_samples_ff, launch_samples_in;
   logic [7:0]         burnout_samples_ff, burnout_samples_in;
   logic [7:0]         falling_samples_ff, falling_samples_in;
   logic [31:0]        launch_time_ff, launch_time_in;
   logic [31:0]        coast_start_ff, coast_start_in;
   logic [23:0]        prev_pressure_ff, prev_pressure_in;
   logic               stage_valid_ff;
   fpd_pkg::stage_type stage_data_ff, stage_data_in;

   logic               accept;
   logic signed [15:0] accel;
   logic signed [15:0] burnout_threshold;
   logic [15:0]        accel_mag;
   logic [31:0]        burn_elapsed;
   logic [31:0]        coast_elapsed;

   function automatic logic [7:0] sat_inc(input logic [7:0] count);
      return (count == 8'hFF) ? count : count + 8'd1;
   endfunction

   assign req_ready = !stage_valid_ff || stage_ready;
   assign accept    = req_valid && req_ready;

   assign accel             = req_payload.accel_vertical;
   assign burnout_threshold = cfg.burnout_accel_threshold;
   // most negative sample wraps to 0x8000, read unsigned as 32768
   assign accel_mag     = accel[15] ? 16'(-accel) : 16'(accel);
   assign burn_elapsed  = req_payload.time_ms - launch_time_ff;
   assign coast_elapsed = req_payload.time_ms - coast_start_ff;

   always_comb begin
      phase_in           = phase_ff;
      launch_samples_in  = launch_samples_ff;
      burnout_samples_in = burnout_samples_ff;
      falling_samples_in = falling_samples_ff;
      launch_time_in     = launch_time_ff;
      coast_start_in     = coast_start_ff;
      prev_pressure_in   = prev_pressure_ff;
      case (phase_ff)
         fpd_pkg::PHASE_IDLE: begin
            launch_samples_in = (accel_mag > {1'b0, cfg.launch_accel_threshold}) ?
                                sat_inc(launch_samples_ff) : 8'd0;
            if (launch_samples_in > cfg.launch_hold_count) begin
               launch_time_in = req_payload.time_ms;
               phase_in       = fpd_pkg::PHASE_LAUNCH;
            end
         end
         fpd_pkg::PHASE_LAUNCH: begin
            burnout_samples_in = (accel < burnout_threshold) ?
                                 sat_inc(burnout_samples_ff) : 8'd0;
            if ((burn_elapsed > {16'd0, cfg.min_burn_ms} && accel[15] &&
                 burnout_samples_in > cfg.burnout_hold_count) ||
                burn_elapsed > {16'd0, cfg.max_burn_ms}) begin
               coast_start_in = req_payload.time_ms;
               phase_in       = fpd_pkg::PHASE_COAST;
            end
         end
         fpd_pkg::PHASE_COAST: begin
            // equal pressure holds the count
            if (req_payload.pressure < prev_pressure_ff &&
                coast_elapsed > 32'(COAST_LOCKOUT_MS)) begin
               falling_samples_in = sat_inc(falling_samples_ff);
            end else if (req_payload.pressure > prev_pressure_ff) begin
               falling_samples_in = 8'd0;
            end
            if (falling_samples_in > cfg.apogee_hold_count ||
                coast_elapsed > {16'd0, cfg.coast_timeout_ms}) begin
               phase_in = fpd_pkg::PHASE_APOGEE;
            end
            prev_pressure_in = req_payload.pressure;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_comb begin
      stage_data_in.phase         = phase_in;
      stage_data_in.sweep         = (phase_ff == fpd_pkg::PHASE_COAST);
      stage_data_in.brake_close   = (phase_ff == fpd_pkg::PHASE_COAST) &&
                                    (phase_in == fpd_pkg::PHASE_APOGEE);
      stage_data_in.coast_elapsed = coast_elapsed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= fpd_pkg::PHASE_IDLE;
         launch_samples_ff  <= 8'd0;
         burnout_samples_ff <= 8'd0;
         falling_samples_ff <= 8'd0;
         launch_time_ff     <= 32'd0;
         coast_start_ff     <= 32'd0;
         prev_pressure_ff   <= 24'd0;
         stage_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff           <= phase_in;
            launch_samples_ff  <= launch_samples_in;
            burnout_samples_ff <= burnout_samples_in;
            falling_samples_ff <= falling_samples_in;
            launch_time_ff     <= launch_time_in;
            coast_start_ff     <= coast_start_in;
            prev_pressure_ff   <= prev_pressure_in;
            stage_valid_ff     <= 1'b1;
         end else if (stage_ready) begin
            stage_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_data_ff <= stage_data_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_data  = stage_data_ff;

endmodule
`default_nettype wire

/* design/fpd_sweep.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_sweep: airbrake test sweep angle
// Two stages: reciprocal multiply for the 5 s period, then remainder, step
// index and angle into the result register.
// ----------------------------------------------------------------------------
module fpd_sweep (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          stage_valid,
   output logic               stage_ready,
   input  wire fpd_pkg::stage_type stage_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output fpd_pkg::rsp_type   rsp_payload
);

   localparam int unsigned   SWEEP_PERIOD_MS = 5000;
   localparam int unsigned   SWEEP_STEP_MS   = 1000;
   localparam int unsigned   SWEEP_STEPS     = SWEEP_PERIOD_MS / SWEEP_STEP_MS;
   localparam int unsigned   STEP_DEG_X4     = 34;
   localparam longint unsigned RECIP_VALUE   = (64'd1 << 32) / SWEEP_PERIOD_MS;
   localparam int unsigned   RECIP_WIDTH     = $clog2(RECIP_VALUE + 1);
   localparam int unsigned   REM_WIDTH       = $clog2(2 * SWEEP_PERIOD_MS);
   localparam int unsigned   STEP_WIDTH      = $clog2(SWEEP_STEPS);
   localparam int unsigned   PROD_WIDTH      = 32 + RECIP_WIDTH;
   localparam int unsigned   BACK_WIDTH      = RECIP_WIDTH + 14;
   localparam int unsigned   ANGLE_X4_WIDTH  = 10;

   localparam logic [RECIP_WIDTH-1:0] RECIP = RECIP_WIDTH'(RECIP_VALUE);

   // stage 1
   logic                    valid1_ff;
   fpd_pkg::phase_type      phase1_ff;
   logic                    sweep1_ff;
   logic                    close1_ff;
   logic [REM_WIDTH-1:0]    elapsed_lo1_ff;
   logic [RECIP_WIDTH-1:0]  quot1_ff;
   logic [PROD_WIDTH-1:0]   product;
   logic                    ready1;
   logic                    load1;

   // result stage
   logic                    rsp_valid_ff;
   fpd_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    ready2;
   logic                    load2;
   logic [BACK_WIDTH-1:0]   back;
   logic [REM_WIDTH-1:0]    rem_raw;
   logic [REM_WIDTH-1:0]    rem;
   logic [STEP_WIDTH-1:0]   step;
   logic [ANGLE_X4_WIDTH-1:0] angle_x4;

   assign ready2      = !rsp_valid_ff || rsp_ready;
   assign ready1      = !valid1_ff || ready2;
   assign stage_ready = ready1;
   assign load1       = stage_valid && ready1;
   assign load2       = valid1_ff && ready2;

   // quotient estimate is exact or one low
   assign product = PROD_WIDTH'(stage_data.coast_elapsed) * PROD_WIDTH'(RECIP);

   // remainder stays below twice the period, so low bits suffice
   assign back    = BACK_WIDTH'(quot1_ff) * BACK_WIDTH'(SWEEP_PERIOD_MS);
   assign rem_raw = elapsed_lo1_ff - back[REM_WIDTH-1:0];
   assign rem     = (rem_raw >= REM_WIDTH'(SWEEP_PERIOD_MS)) ?
                    rem_raw - REM_WIDTH'(SWEEP_PERIOD_MS) : rem_raw;

   always_comb begin
      step = '0;
      for (int i = 1; i < SWEEP_STEPS; i++) begin
         if (rem >= REM_WIDTH'(i * SWEEP_STEP_MS)) begin
            step = STEP_WIDTH'(i);
         end
      end
   end

   // truncated 180 - 8.5 * step
   assign angle_x4 = ANGLE_X4_WIDTH'(4 * fpd_pkg::SERVO_HOME_DEG) -
                     ANGLE_X4_WIDTH'(STEP_DEG_X4) * ANGLE_X4_WIDTH'(step);

   always_comb begin
      rsp_in.phase       = phase1_ff;
      rsp_in.servo_write = sweep1_ff;
      if (!sweep1_ff) begin
         rsp_in.servo_angle = 8'd0;
      end else if (close1_ff) begin
         rsp_in.servo_angle = fpd_pkg::SERVO_HOME_DEG;
      end else begin
         rsp_in.servo_angle = 8'(angle_x4 >> 2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load1) begin
            valid1_ff <= 1'b1;
         end else if (ready2) begin
            valid1_ff <= 1'b0;
         end
         if (load2) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         phase1_ff      <= stage_data.phase;
         sweep1_ff      <= stage_data.sweep;
         close1_ff      <= stage_data.brake_close;
         elapsed_lo1_ff <= stage_data.coast_elapsed[REM_WIDTH-1:0];
         quot1_ff       <= product[PROD_WIDTH-1:32];
      end
      if (load2) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

/* design/rocket_flight_phase_detector.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rocket_flight_phase_detector: flight phase detector top level
// Phase machine for idle, launch, coast and apogee with airbrake test sweep.
// ----------------------------------------------------------------------------
//  channel  ports                              word
//  req      req_valid / req_ready              time_ms, accel_vertical, pressure
//  rsp      rsp_valid / rsp_ready              phase, servo_write, servo_angle
//  csr      csr_write_enable, index, wdata     8 registers, write only
//
//  One word per cycle sustained while results are taken; a taken word passes
//  through the registered state pass, reciprocal multiply, remainder and angle.
//  The phase machine updates in the cycle a word is taken, so the next
//  word sees the new state at once.
//  Reset clears the phase, counters and pipeline and loads register defaults.
//  A stalled result holds the pipeline; words keep coming in until every
//  stage is full.
// ----------------------------------------------------------------------------
module rocket_flight_phase_detector #(
   parameter int unsigned COAST_LOCKOUT_MS = fpd_pkg::COAST_LOCKOUT_MS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire fpd_pkg::req_type                    req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output fpd_pkg::rsp_type                         rsp_payload,
   input  wire logic                                csr_write_enable,
   input  wire logic [fpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [fpd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   fpd_pkg::cfg_type   cfg;
   logic               stage_valid;
   logic               stage_ready;
   fpd_pkg::stage_type stage_data;

   fpd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   fpd_core #(
      .COAST_LOCKOUT_MS (COAST_LOCKOUT_MS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage_data  (stage_data)
   );

   fpd_sweep u_sweep (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage_data  (stage_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

/* design/fpd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_checker: flight phase detector port checks
// Result word rules and pipeline readiness seen at the top level ports.
// ----------------------------------------------------------------------------
module fpd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire fpd_pkg::rsp_type rsp_payload
);

   // stalled result holds its word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
   else $error("result word changed while stalled");

   // empty result register means no stage can be blocking input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
   else $error("input stalled with result side empty");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.servo_write |-> rsp_payload.servo_angle == 8'd0)
   else $error("servo angle set without a servo write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.servo_write |->
         rsp_payload.phase == fpd_pkg::PHASE_COAST ||
         rsp_payload.phase == fpd_pkg::PHASE_APOGEE)
   else $error("servo write outside coast");

   // the step that reaches apogee closes the brake
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.servo_write &&
      rsp_payload.phase == fpd_pkg::PHASE_APOGEE |->
         rsp_payload.servo_angle == fpd_pkg::SERVO_HOME_DEG)
   else $error("apogee write not at home angle");

endmodule

bind rocket_flight_phase_detector fpd_checker u_fpd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

/* verif/tb_rocket_flight_phase_detector.sv */
// ----------------------------------------------------------------------------
// tb_rocket_flight_phase_detector: self-checking bench for the phase detector
// Flies one randomized flight through idle, launch, coast and apogee under
// several register settings. Every accepted sample is run through a local
// flight model, and each result word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_rocket_flight_phase_detector;
   timeunit 1ns;
   timeprecision 1ps;

   import fpd_pkg::*;

   localparam int unsigned COAST_LOCKOUT = COAST_LOCKOUT_MS_DEFAULT;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   req_type                    req_payload      = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   rsp_type                    rsp_payload;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = CSR_LAUNCH_ACCEL_THRESHOLD;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata        = '0;

   rocket_flight_phase_detector #(
      .COAST_LOCKOUT_MS(COAST_LOCKOUT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   // flight model state and its copy of the registers
   cfg_type     limits;
   phase_type   phase_now;
   int          launch_run;
   int          burn_run;
   int          fall_run;
   logic [31:0] launch_stamp;
   logic [31:0] coast_stamp;
   logic [23:0] last_pressure;

   req_type     sample_queue[$];
   rsp_type     report_queue[$];
   int          fault_count = 0;

   logic        calm        = 1'b0;
   logic        choke_ask   = 1'b0;
   logic        choke_spent;
   int          choke_left;

   logic [31:0] stamp;
   logic [23:0] baro;

   function automatic int bump(input int count);
      return (count < 255) ? count + 1 : 255;
   endfunction

   function automatic rsp_type next_flight_report(input req_type w);
      rsp_type     r;
      int          a;
      int          mag;
      logic [31:0] span;
      int unsigned k;
      r = '0;
      a = $signed(w.accel_vertical);
      case (phase_now)
         PHASE_IDLE: begin
            mag = (a < 0) ? -a : a;
            launch_run = (mag > int'(limits.launch_accel_threshold)) ? bump(launch_run) : 0;
            if (launch_run > int'(limits.launch_hold_count)) begin
               launch_stamp = w.time_ms;
               phase_now    = PHASE_LAUNCH;
            end
         end
         PHASE_LAUNCH: begin
            span     = w.time_ms - launch_stamp;
            burn_run = (a < int'($signed(limits.burnout_accel_threshold))) ? bump(burn_run) : 0;
            if ((span > 32'(limits.min_burn_ms) && a < 0
                 && burn_run > int'(limits.burnout_hold_count))
                || span > 32'(limits.max_burn_ms)) begin
               phase_now   = PHASE_COAST;
               coast_stamp = w.time_ms;
            end
         end
         PHASE_COAST: begin
            span          = w.time_ms - coast_stamp;
            k             = (span / 1000) % 5;
            r.servo_write = 1'b1;
            r.servo_angle = 8'((720 - 34 * k) / 4);
            if (w.pressure < last_pressure && span > 32'(COAST_LOCKOUT))
               fall_run = bump(fall_run);
            else if (w.pressure > last_pressure)
               fall_run = 0;
            if (fall_run > int'(limits.apogee_hold_count)
                || span > 32'(limits.coast_timeout_ms)) begin
               phase_now     = PHASE_APOGEE;
               r.servo_angle = SERVO_HOME_DEG;
            end
            last_pressure = w.pressure;
         end
         default: ;
      endcase
      r.phase = phase_now;
      return r;
   endfunction

   // sender: offer queued samples, idle now and then
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            report_queue.push_back(next_flight_report(req_payload));
            void'(sample_queue.pop_front());
         end
         if (sample_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
            req_valid   <= 1'b1;
            req_payload <= sample_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         choke_left  <= 0;
         choke_spent <= 1'b0;
      end else if (choke_ask && !choke_spent) begin
         choke_left  <= 300;
         choke_spent <= 1'b1;
         rsp_ready   <= 1'b0;
      end else if (choke_left != 0) begin
         choke_left <= choke_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 7);
      end
   end

   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (report_queue.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected result word: phase %0d servo %0b angle %0d",
                        rsp_payload.phase, rsp_payload.servo_write, rsp_payload.servo_angle);
         end else begin
            want = report_queue.pop_front();
            if (rsp_payload.phase !== want.phase
                || rsp_payload.servo_write !== want.servo_write
                || rsp_payload.servo_angle !== want.servo_angle) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("result mismatch: expected phase %0d servo %0b angle %0d, %s %0d %0b %0d",
                           want.phase, want.servo_write, want.servo_angle, "got",
                           rsp_payload.phase, rsp_payload.servo_write, rsp_payload.servo_angle);
            end
         end
      end
   end

   task automatic offer(input logic [31:0] t, input logic signed [15:0] a,
                        input logic [23:0] p);
      req_type w;
      w.time_ms        = t;
      w.accel_vertical = a;
      w.pressure       = p;
      sample_queue.push_back(w);
   endtask

   // wait until every sample is taken and every result word is back
   task automatic drain();
      while (sample_queue.size() != 0 || req_valid || report_queue.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_register(input csr_index_type idx, input logic [15:0] value);
      // junk in the unused upper byte of the count registers
      if (idx == CSR_LAUNCH_HOLD_COUNT || idx == CSR_BURNOUT_HOLD_COUNT
          || idx == CSR_APOGEE_HOLD_COUNT)
         value[15:8] = 8'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      case (idx)
         CSR_LAUNCH_ACCEL_THRESHOLD:  limits.launch_accel_threshold  = value[14:0];
         CSR_LAUNCH_HOLD_COUNT:       limits.launch_hold_count       = value[7:0];
         CSR_BURNOUT_ACCEL_THRESHOLD: limits.burnout_accel_threshold = value;
         CSR_BURNOUT_HOLD_COUNT:      limits.burnout_hold_count      = value[7:0];
         CSR_MIN_BURN_MS:             limits.min_burn_ms             = value;
         CSR_MAX_BURN_MS:             limits.max_burn_ms             = value;
         CSR_APOGEE_HOLD_COUNT:       limits.apogee_hold_count       = value[7:0];
         CSR_COAST_TIMEOUT_MS:        limits.coast_timeout_ms        = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random samples at random times, accel never zero
   task automatic scatter(input int n);
      logic signed [15:0] a;
      for (int i = 0; i < n; i++) begin
         a = 16'($urandom);
         if (a == 0)
            a = 1;
         offer($urandom, a, 24'($urandom));
      end
   endtask

   task automatic step_baro(input int fall_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < fall_pct)
         baro = baro - 24'($urandom_range(1, 500));
      else if (roll >= fall_pct + 15)
         baro = baro + 24'($urandom_range(1, 300));
   endtask

   // advancing time, pressure trend, accel anything but full scale positive
   task automatic cruise(input int n, input int lo_ms, input int hi_ms, input int fall_pct);
      logic signed [15:0] a;
      for (int i = 0; i < n; i++) begin
         stamp = stamp + 32'($urandom_range(lo_ms, hi_ms));
         step_baro(fall_pct);
         a = 16'($urandom);
         if (a == 16'sh7FFF)
            a = 16'sh7FFE;
         offer(stamp, a, baro);
      end
   endtask

   initial begin
      #2_000_000;
      $display("tb_rocket_flight_phase_detector NOT OK");
      $finish;
   end

   initial begin
      int made;
      int len;
      int thr;
      int hold;
      int m;
      int e_now;
      int d_now;
      logic signed [15:0] a;

      limits.launch_accel_threshold  = LAUNCH_ACCEL_THRESHOLD_RESET;
      limits.launch_hold_count       = LAUNCH_HOLD_COUNT_RESET;
      limits.burnout_accel_threshold = BURNOUT_ACCEL_THRESHOLD_RESET;
      limits.burnout_hold_count      = BURNOUT_HOLD_COUNT_RESET;
      limits.min_burn_ms             = MIN_BURN_MS_RESET;
      limits.max_burn_ms             = MAX_BURN_MS_RESET;
      limits.apogee_hold_count       = APOGEE_HOLD_COUNT_RESET;
      limits.coast_timeout_ms        = COAST_TIMEOUT_MS_RESET;
      phase_now     = PHASE_IDLE;
      launch_run    = 0;
      burn_run      = 0;
      fall_run      = 0;
      launch_stamp  = '0;
      coast_stamp   = '0;
      last_pressure = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // field extremes and threshold edges at the reset settings
      offer(32'd0, 16'sd0, 24'd0);
      offer(32'hFFFF_FFFF, 16'sh7FFF, 24'hFF_FFFF);
      offer(32'd1, 16'sh8000, 24'h80_0000);
      offer(32'd2, 16'sd6144, 24'd1);
      offer(32'd3, 16'sd6145, 24'd2);
      offer(32'd4, -16'sd6145, 24'd3);
      offer(32'd5, -16'sd6144, 24'd4);
      drain();

      // top threshold, bit 15 must drop; only the most negative accel counts
      put_register(CSR_LAUNCH_ACCEL_THRESHOLD, 16'hFFFF);
      put_register(CSR_LAUNCH_HOLD_COUNT, 16'd255);
      offer(32'd6, 16'sh8000, 24'd5);
      offer(32'd7, 16'sh7FFF, 24'd6);
      offer(32'd8, 16'sh8000, 24'd7);
      offer(32'd9, 16'sh8001, 24'd8);
      scatter(40);
      drain();

      // runs of hard acceleration that stop short of the hold count
      thr  = $urandom_range(1000, 12000);
      hold = $urandom_range(10, 40);
      put_register(CSR_LAUNCH_ACCEL_THRESHOLD, 16'(thr));
      put_register(CSR_LAUNCH_HOLD_COUNT, 16'(hold));
      made = 0;
      while (made < 80) begin
         len = $urandom_range(0, hold);
         for (int i = 0; i < len; i++) begin
            m = $urandom_range(thr + 1, 32768);
            a = ($urandom_range(0, 1) || m == 32768) ? 16'(-m) : 16'(m);
            offer($urandom, a, 24'($urandom));
         end
         len = len + $urandom_range(1, 3);
         for (int i = made + len - $urandom_range(1, 3); i < made + len; i++) begin
            m = $urandom_range(0, thr);
            a = $urandom_range(0, 1) ? 16'(-m) : 16'(m);
            offer($urandom, a, 24'($urandom));
         end
         made = made + len;
      end
      drain();

      // zero threshold, hold out of reach: drive the launch count to saturation
      put_register(CSR_LAUNCH_ACCEL_THRESHOLD, 16'd0);
      put_register(CSR_LAUNCH_HOLD_COUNT, 16'd255);
      @(posedge clock);
      calm <= 1'b1;
      scatter(260);
      drain();
      calm <= 1'b0;

      // arm the later phases, then lower the hold so the saturated count launches
      put_register(CSR_MIN_BURN_MS, 16'hFFFF);
      put_register(CSR_MAX_BURN_MS, 16'hFFFF);
      put_register(CSR_BURNOUT_ACCEL_THRESHOLD, 16'h8000);
      put_register(CSR_BURNOUT_HOLD_COUNT, 16'd0);
      put_register(CSR_APOGEE_HOLD_COUNT, 16'd255);
      put_register(CSR_COAST_TIMEOUT_MS, 16'hFFFF);
      put_register(CSR_LAUNCH_HOLD_COUNT,
                   $urandom_range(0, 1) ? 16'd254 : 16'($urandom_range(0, 253)));
      stamp = 32'hFFFF_FFFF - 32'($urandom_range(0, 30000));
      baro  = 24'($urandom_range(24'h80_0000, 24'hC0_0000));
      offer(stamp, 16'sh4000, baro);
      cruise(10, 0, 150, 50);
      drain();

      // burnout count runs to saturation while the receiver backs up
      put_register(CSR_BURNOUT_ACCEL_THRESHOLD, 16'h7FFF);
      put_register(CSR_BURNOUT_HOLD_COUNT, 16'd255);
      @(posedge clock);
      choke_ask <= 1'b1;
      cruise(262, 0, 150, 50);
      drain();

      // count above hold, but the minimum burn time still holds launch
      put_register(CSR_BURNOUT_HOLD_COUNT, 16'd254);
      cruise(20, 0, 150, 50);
      drain();

      e_now = stamp - launch_stamp;
      if ($urandom_range(0, 1)) begin
         put_register(CSR_MIN_BURN_MS, 16'($urandom_range(0, e_now)));
         for (int i = 0; i < 10; i++) begin
            stamp = stamp + 32'($urandom_range(1, 150));
            m     = (i < 2) ? $urandom_range(0, 32766) : -$urandom_range(1, 32768);
            offer(stamp, 16'(m), baro);
         end
      end else begin
         put_register(CSR_MAX_BURN_MS,
                      $urandom_range(0, 1) ? 16'd0 : 16'(e_now + $urandom_range(0, 600)));
         cruise(10, 100, 150, 50);
      end
      drain();

      // coast sweep through the lockout with a noisy pressure trend
      cruise(100, 100, 250, 60);
      drain();

      if ($urandom_range(0, 1)) begin
         put_register(CSR_APOGEE_HOLD_COUNT,
                      $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 40)));
         cruise(60, 50, 250, 90);
      end else begin
         d_now = stamp - coast_stamp;
         put_register(CSR_COAST_TIMEOUT_MS,
                      $urandom_range(0, 1) ? 16'd0 : 16'(d_now + $urandom_range(0, 2000)));
         cruise(30, 100, 250, 50);
      end
      drain();

      scatter(30);
      drain();
      repeat (8) @(posedge clock);

      if (fault_count == 0 && report_queue.size() == 0)
         $display("tb_rocket_flight_phase_detector OK");
      else
         $display("tb_rocket_flight_phase_detector NOT OK");
      $finish;
   end

endmodule
